FILE: rtl/core/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg: shared types and constants for the bounded deque
// Sizes, command and status codes, controller commands and element helpers.
// ----------------------------------------------------------------------------
package bdeq_pkg;

	localparam int DEPTH         = 64;
	localparam int ELEMENT_WIDTH = 32;
	localparam int PTR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W         = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	function automatic logic [ELEMENT_WIDTH-1:0] to_elem(input logic [31:0] v);
		logic signed [63:0] w;
		w = 64'(signed'(v));
		return w[ELEMENT_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] to_data(input logic [ELEMENT_WIDTH-1:0] e);
		logic signed [63:0] w;
		w = 64'(signed'(e));
		return w[31:0];
	endfunction

	function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] head,
			input logic [31:0] pos);
		logic [31:0] s;
		s = 32'(head) + pos;
		if (s >= 32'(DEPTH)) begin
			s = s - 32'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

FILE: rtl/core/bdeq_ctrl.sv
// ----------------------------------------------------------------------------
// bdeq_ctrl: command sequencer
// Takes one item, runs it through the datapath, holds the result until taken.
// ----------------------------------------------------------------------------
module bdeq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output bdeq_pkg::cmd_t   cmd
);

	bdeq_pkg::state_t state_q;
	bdeq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdeq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			bdeq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bdeq_pkg::S_EXEC;
				end
			end
			bdeq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = bdeq_pkg::S_RESP;
			end
			bdeq_pkg::S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = bdeq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bdeq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/bdeq_dpath.sv
// ----------------------------------------------------------------------------
// bdeq_dpath: ring memory, head pointer and element count
// Decodes the latched command, does at most one memory access and updates pointers.
// ----------------------------------------------------------------------------
module bdeq_dpath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bdeq_pkg::cmd_t        cmd,
	input  logic [2:0]            operation,
	input  logic signed [31:0]    value,
	input  logic [5:0]            index,
	output logic signed [31:0]    data,
	output logic [6:0]            count,
	output logic                  is_empty,
	output logic [1:0]            status
);

	logic [bdeq_pkg::ELEMENT_WIDTH-1:0] mem [bdeq_pkg::DEPTH];

	logic [2:0]                         op_q;
	logic [bdeq_pkg::ELEMENT_WIDTH-1:0] val_q;
	logic [5:0]                         idx_q;

	logic [bdeq_pkg::PTR_W-1:0]         head_q;
	logic [bdeq_pkg::CNT_W-1:0]         count_q;
	bdeq_pkg::status_t                  status_q;
	logic                               rd_sel_q;
	logic [bdeq_pkg::ELEMENT_WIDTH-1:0] rdata_q;

	logic [bdeq_pkg::PTR_W-1:0]         head_d;
	logic [bdeq_pkg::CNT_W-1:0]         count_d;
	bdeq_pkg::status_t                  status_d;
	logic                               rd_sel_d;
	logic                               mem_we;
	logic                               mem_re;
	logic [bdeq_pkg::PTR_W-1:0]         mem_addr;
	logic                               full;
	logic                               empty;
	logic                               idx_bad;

	assign full    = (count_q >= bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH));
	assign empty   = (count_q == '0);
	assign idx_bad = (32'(idx_q) >= 32'(count_q));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			val_q <= bdeq_pkg::to_elem(value);
			idx_q <= index;
		end
	end

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = bdeq_pkg::ST_OK;
		rd_sel_d = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = '0;
		case (op_q)
			bdeq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_d = bdeq_pkg::ST_FULL;
				end else begin
					mem_we   = 1'b1;
					mem_addr = bdeq_pkg::ring_slot(head_q, 32'(count_q));
					count_d  = count_q + bdeq_pkg::CNT_W'(1);
				end
			end
			bdeq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = bdeq_pkg::ST_FULL;
				end else begin
					head_d   = (head_q == '0) ? bdeq_pkg::PTR_W'(bdeq_pkg::DEPTH - 1)
						: head_q - bdeq_pkg::PTR_W'(1);
					mem_we   = 1'b1;
					mem_addr = head_d;
					count_d  = count_q + bdeq_pkg::CNT_W'(1);
				end
			end
			bdeq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status_d = bdeq_pkg::ST_EMPTY;
				end else begin
					count_d  = count_q - bdeq_pkg::CNT_W'(1);
					mem_re   = 1'b1;
					rd_sel_d = 1'b1;
					mem_addr = bdeq_pkg::ring_slot(head_q, 32'(count_d));
				end
			end
			bdeq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = bdeq_pkg::ST_EMPTY;
				end else begin
					mem_re   = 1'b1;
					rd_sel_d = 1'b1;
					mem_addr = head_q;
					count_d  = count_q - bdeq_pkg::CNT_W'(1);
					head_d   = (count_d == '0) ? '0 : bdeq_pkg::ring_slot(head_q, 32'd1);
				end
			end
			bdeq_pkg::OP_READ: begin
				if (idx_bad) begin
					status_d = bdeq_pkg::ST_RANGE;
				end else begin
					mem_re   = 1'b1;
					rd_sel_d = 1'b1;
					mem_addr = bdeq_pkg::ring_slot(head_q, 32'(idx_q));
				end
			end
			bdeq_pkg::OP_WRITE: begin
				if (idx_bad) begin
					status_d = bdeq_pkg::ST_RANGE;
				end else begin
					mem_we   = 1'b1;
					mem_addr = bdeq_pkg::ring_slot(head_q, 32'(idx_q));
				end
			end
			bdeq_pkg::OP_CLEAR: begin
				head_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// single-port ring storage, registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[mem_addr] <= val_q;
		end
		if (cmd.exec && mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			status_q <= bdeq_pkg::ST_OK;
			rd_sel_q <= 1'b0;
		end else if (cmd.exec) begin
			head_q   <= head_d;
			count_q  <= count_d;
			status_q <= status_d;
			rd_sel_q <= rd_sel_d;
		end
	end

	assign data     = rd_sel_q ? signed'(bdeq_pkg::to_data(rdata_q)) : '0;
	assign count    = 7'(count_q);
	assign is_empty = (count_q == '0);
	assign status   = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(bdeq_pkg::DEPTH))
		else $error("element count beyond depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		status_q == bdeq_pkg::ST_FULL |-> count_q == bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		status_q == bdeq_pkg::ST_EMPTY |-> count_q == '0)
		else $error("empty status with elements held");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rd_sel_q |-> status_q == bdeq_pkg::ST_OK)
		else $error("data returned on failed command");

endmodule

FILE: rtl/core/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue: bounded deque of signed elements
// Push/pop at either end, indexed read/write and clear over a ring memory.
// ----------------------------------------------------------------------------
// One command is taken at a time: an item is latched in the idle state, does
// at most one access to the ring memory (whose read data is registered) in
// the execute state, and is then offered as a result in the response state
// until out_ready takes it. The single-port memory access and its registered
// read set these steps. No clearing pass is needed after reset; the queue is
// empty at once.
module bounded_double_ended_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic signed [31:0] value,
	input  logic [5:0]         index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] data,
	output logic [6:0]         count,
	output logic               is_empty,
	output logic [1:0]         status
);

	bdeq_pkg::cmd_t cmd;

	bdeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bdeq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (operation),
		.value     (value),
		.index     (index),
		.data      (data),
		.count     (count),
		.is_empty  (is_empty),
		.status    (status)
	);

endmodule

FILE: sim/bounded_double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_tb: self-checking bench for the bounded deque
// Pushes, pops, indexed reads/writes and clears go through a shadow deque that
// predicts every result; results are checked in order, field by field, while
// the command and result sides idle and stall at random in phases two to four.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_tb;

	localparam logic [2:0] OP_UNUSED   = 3'd7;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         RANDOM_PER_PHASE = 150;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] val;
		logic [5:0]  idx;
	} deque_cmd_t;

	typedef struct {
		logic [31:0]         data;
		logic [6:0]          cnt;
		logic                empty;
		bdeq_pkg::status_t   st;
	} deque_answer_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         operation;
	logic signed [31:0] value;
	logic [5:0]         index;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] data;
	logic [6:0]         count;
	logic               is_empty;
	logic [1:0]         status;

	deque_cmd_t    cmd_backlog[$];
	deque_answer_t deque_answers[$];
	int            issued;
	int            taken;
	int            gap_pct;
	int            stall_pct;
	int            errors;
	int            cycles;

	// shadow deque
	logic [bdeq_pkg::ELEMENT_WIDTH-1:0] shadow_ring [bdeq_pkg::DEPTH];
	int                                 shadow_head;
	int                                 shadow_fill;

	// stimulus-side view of the fill level
	int                       planned_fill;
	bit                       growing;

	bounded_double_ended_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.value     (value),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (data),
		.count     (count),
		.is_empty  (is_empty),
		.status    (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int ring_pos(input int pos);
		return (shadow_head + pos) % bdeq_pkg::DEPTH;
	endfunction

	function automatic logic [31:0] widen(input logic [bdeq_pkg::ELEMENT_WIDTH-1:0] e);
		logic signed [bdeq_pkg::ELEMENT_WIDTH-1:0] se;
		logic signed [63:0]                        w;
		se = e;
		w = se;
		return w[31:0];
	endfunction

	function automatic deque_answer_t apply_command(input logic [2:0] op,
			input logic [31:0] val, input logic [5:0] idx);
		deque_answer_t                      ans;
		logic signed [63:0]                 w;
		logic [bdeq_pkg::ELEMENT_WIDTH-1:0] elem;
		w = signed'(val);
		elem = w[bdeq_pkg::ELEMENT_WIDTH-1:0];
		ans.data = '0;
		ans.st = bdeq_pkg::ST_OK;
		case (op)
			bdeq_pkg::OP_PUSH_BACK: begin
				if (shadow_fill >= bdeq_pkg::DEPTH) begin
					ans.st = bdeq_pkg::ST_FULL;
				end else begin
					shadow_ring[ring_pos(shadow_fill)] = elem;
					shadow_fill++;
				end
			end
			bdeq_pkg::OP_PUSH_FRONT: begin
				if (shadow_fill >= bdeq_pkg::DEPTH) begin
					ans.st = bdeq_pkg::ST_FULL;
				end else begin
					shadow_head = (shadow_head == 0) ? bdeq_pkg::DEPTH - 1
						: shadow_head - 1;
					shadow_ring[shadow_head] = elem;
					shadow_fill++;
				end
			end
			bdeq_pkg::OP_POP_BACK: begin
				if (shadow_fill == 0) begin
					ans.st = bdeq_pkg::ST_EMPTY;
				end else begin
					shadow_fill--;
					ans.data = widen(shadow_ring[ring_pos(shadow_fill)]);
				end
			end
			bdeq_pkg::OP_POP_FRONT: begin
				if (shadow_fill == 0) begin
					ans.st = bdeq_pkg::ST_EMPTY;
				end else begin
					ans.data = widen(shadow_ring[shadow_head]);
					shadow_head = ring_pos(1);
					shadow_fill--;
					if (shadow_fill == 0) begin
						shadow_head = 0;
					end
				end
			end
			bdeq_pkg::OP_READ: begin
				if (int'(idx) >= shadow_fill) begin
					ans.st = bdeq_pkg::ST_RANGE;
				end else begin
					ans.data = widen(shadow_ring[ring_pos(idx)]);
				end
			end
			bdeq_pkg::OP_WRITE: begin
				if (int'(idx) >= shadow_fill) begin
					ans.st = bdeq_pkg::ST_RANGE;
				end else begin
					shadow_ring[ring_pos(idx)] = elem;
				end
			end
			bdeq_pkg::OP_CLEAR: begin
				shadow_head = 0;
				shadow_fill = 0;
			end
			default: begin
			end
		endcase
		ans.cnt = shadow_fill[6:0];
		ans.empty = (shadow_fill == 0);
		return ans;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic add_cmd(input logic [2:0] op, input logic [31:0] val,
			input logic [5:0] idx);
		deque_cmd_t c;
		c.op = op;
		c.val = val;
		c.idx = idx;
		cmd_backlog = {cmd_backlog, c};
		case (op)
			bdeq_pkg::OP_PUSH_BACK, bdeq_pkg::OP_PUSH_FRONT:
				if (planned_fill < bdeq_pkg::DEPTH) planned_fill++;
			bdeq_pkg::OP_POP_BACK, bdeq_pkg::OP_POP_FRONT:
				if (planned_fill > 0) planned_fill--;
			bdeq_pkg::OP_CLEAR: planned_fill = 0;
			default: begin
			end
		endcase
	endtask

	// random walk that fills the deque to the top, then drains it to empty
	task automatic add_random_cmd();
		int          r;
		logic [2:0]  op;
		logic [31:0] val;
		logic [5:0]  idx;
		if (growing && planned_fill == bdeq_pkg::DEPTH && $urandom_range(3) == 0) begin
			growing = 1'b0;
		end else if (!growing && planned_fill == 0 && $urandom_range(3) == 0) begin
			growing = 1'b1;
		end
		r = $urandom_range(99);
		if (growing) begin
			if (r < 60)
				op = $urandom_range(1) ? bdeq_pkg::OP_PUSH_FRONT : bdeq_pkg::OP_PUSH_BACK;
			else if (r < 74) op = bdeq_pkg::OP_READ;
			else if (r < 86) op = bdeq_pkg::OP_WRITE;
			else if (r < 97)
				op = $urandom_range(1) ? bdeq_pkg::OP_POP_FRONT : bdeq_pkg::OP_POP_BACK;
			else             op = OP_UNUSED;
		end else begin
			if (r < 55)
				op = $urandom_range(1) ? bdeq_pkg::OP_POP_FRONT : bdeq_pkg::OP_POP_BACK;
			else if (r < 70) op = bdeq_pkg::OP_READ;
			else if (r < 82) op = bdeq_pkg::OP_WRITE;
			else if (r < 96)
				op = $urandom_range(1) ? bdeq_pkg::OP_PUSH_FRONT : bdeq_pkg::OP_PUSH_BACK;
			else if (r < 98) op = bdeq_pkg::OP_CLEAR;
			else             op = OP_UNUSED;
		end
		case ($urandom_range(19))
			0:       val = 32'h7FFF_FFFF;
			1:       val = 32'h8000_0000;
			2:       val = 32'hFFFF_FFFF;
			3:       val = 32'h0;
			default: val = $urandom();
		endcase
		if (planned_fill != 0 && $urandom_range(4) != 0) begin
			idx = 6'($urandom_range(planned_fill - 1));
		end else begin
			idx = 6'($urandom_range(63));
		end
		add_cmd(op, val, idx);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("bounded_double_ended_queue_tb: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin : drive_cmds
		deque_cmd_t nxt;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= stall_pct);
			if (issued == taken) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
					nxt = cmd_backlog[0];
					cmd_backlog.delete(0);
					in_valid  <= 1'b1;
					operation <= nxt.op;
					value     <= nxt.val;
					index     <= nxt.idx;
					issued    <= issued + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		deque_answer_t want;
		deque_answer_t pred;
		if (arst_n && in_valid && in_ready) begin
			pred = apply_command(operation, value, index);
			deque_answers = {deque_answers, pred};
			taken <= taken + 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (deque_answers.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = deque_answers[0];
				deque_answers.delete(0);
				if (data !== want.data)
					report_mismatch($sformatf("data exp %h got %h", want.data, data));
				if (count !== want.cnt)
					report_mismatch($sformatf("count exp %0d got %0d", want.cnt, count));
				if (is_empty !== want.empty)
					report_mismatch($sformatf("is_empty exp %b got %b", want.empty,
						is_empty));
				if (status !== want.st)
					report_mismatch($sformatf("status exp %0d got %0d", want.st, status));
			end
		end
	end

	initial begin
		int ph;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		value = '0;
		index = '0;
		out_ready = 1'b0;
		issued = 0;
		taken = 0;
		errors = 0;
		cycles = 0;
		gap_pct = 0;
		stall_pct = 0;
		shadow_head = 0;
		shadow_fill = 0;
		planned_fill = 0;
		growing = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty-queue errors, unused opcode, value extremes, range errors, wrap
		add_cmd(bdeq_pkg::OP_POP_BACK, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_POP_FRONT, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_WRITE, 32'hDEAD_BEEF, 6'd63);
		add_cmd(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
		add_cmd(bdeq_pkg::OP_CLEAR, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 6'd0);
		add_cmd(bdeq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 6'd0);
		add_cmd(bdeq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 6'd0);
		add_cmd(bdeq_pkg::OP_PUSH_FRONT, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd3);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd4);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd63);
		add_cmd(bdeq_pkg::OP_WRITE, 32'hA5A5_A5A5, 6'd2);
		add_cmd(bdeq_pkg::OP_WRITE, 32'h5A5A_5A5A, 6'd4);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd2);
		add_cmd(bdeq_pkg::OP_POP_FRONT, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_POP_BACK, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_POP_FRONT, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_POP_FRONT, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_PUSH_FRONT, 32'h1234_5678, 6'd0);
		add_cmd(bdeq_pkg::OP_PUSH_FRONT, 32'h8765_4321, 6'd0);
		add_cmd(bdeq_pkg::OP_CLEAR, 32'h0, 6'd0);
		add_cmd(bdeq_pkg::OP_READ, 32'h0, 6'd0);

		for (ph = 0; ph < 4; ph++) begin
			gap_pct   = (ph == 1) ? 50 : (ph == 3) ? 29 : 0;
			stall_pct = (ph == 2) ? 50 : (ph == 3) ? 29 : 0;
			repeat (RANDOM_PER_PHASE) add_random_cmd();
			while (cmd_backlog.size() != 0 || issued != taken) @(posedge clk);
		end

		while (deque_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("bounded_double_ended_queue_tb: PASS");
		end else begin
			$display("bounded_double_ended_queue_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: bounded_double_ended_queue.f
rtl/core/bdeq_pkg.sv
rtl/core/bdeq_ctrl.sv
rtl/core/bdeq_dpath.sv
rtl/core/bounded_double_ended_queue.sv
sim/bounded_double_ended_queue_tb.sv
